@@ hw/rtl/escmps_pkg.sv @@
// ----------------------------------------------------------------------------
// escmps_pkg
// Shared types, constants and control store for the ESC arming pulse shaper.
// ----------------------------------------------------------------------------
package escmps_pkg;

   // field widths
   localparam int MOTOR_COUNT_DEF = 4;
   localparam int CMD_W           = 18;
   localparam int NOW_W           = 32;
   localparam int PULSE_W         = 16;
   localparam int PHASE_W         = 2;
   localparam int CFG_W           = 17;
   localparam int Q16_W           = 17;
   localparam int PROD_W          = 34;
   localparam int ACC_W           = 35;

   // fixed values
   localparam logic [Q16_W-1:0]   Q16_ONE        = 17'd65536;
   localparam logic [ACC_W-1:0]   ROUND_HALF     = 35'd32768;
   localparam logic [PULSE_W-1:0] DEFAULT_PERIOD = 16'd20000;

   // register reset values
   localparam logic [15:0] RST_PULSE_LOW  = 16'd1000;
   localparam logic [15:0] RST_PULSE_HIGH = 16'd2000;
   localparam logic [15:0] RST_PERIOD     = 16'd19999;
   localparam logic [15:0] RST_LOW_HOLD   = 16'd5000;
   localparam logic [15:0] RST_MID_HOLD   = 16'd500;
   localparam logic [15:0] RST_MID_PULSE  = 16'd1500;
   localparam logic [16:0] RST_ALPHA      = 17'd39322;

   // register index codes
   typedef enum logic [2:0] {
      CSR_PULSE_LOW   = 3'd0,
      CSR_PULSE_HIGH  = 3'd1,
      CSR_PERIOD      = 3'd2,
      CSR_LOW_HOLD    = 3'd3,
      CSR_MID_HOLD    = 3'd4,
      CSR_MID_PULSE   = 3'd5,
      CSR_SMOOTH_ALPHA = 3'd6
   } csr_index_type;

   // arming phase
   typedef enum logic [PHASE_W-1:0] {
      PH_LOW   = 2'd0,
      PH_MID   = 2'd1,
      PH_ARMED = 2'd2
   } phase_type;

   // multiplier operand selection
   typedef enum logic [1:0] {
      MUL_NONE = 2'd0,
      MUL_CMD  = 2'd1,
      MUL_PREV = 2'd2,
      MUL_SPAN = 2'd3
   } mul_sel_type;

   // sequencer flow control
   typedef enum logic [1:0] {
      JMP_NEXT   = 2'd0,
      JMP_LOOP   = 2'd1,
      JMP_FINISH = 2'd2
   } jump_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_MUL_CMD  = 3'd0;
   localparam step_type STEP_MUL_PREV = 3'd1;
   localparam step_type STEP_AVG      = 3'd2;
   localparam step_type STEP_MUL_SPAN = 3'd3;
   localparam step_type STEP_MAP      = 3'd4;
   localparam step_type STEP_FINISH   = 3'd5;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        avg_write;
      logic        pulse_write;
      jump_type    jump;
      step_type    target;
   } ucode_type;

   // control group from sequencer to datapath
   typedef struct packed {
      mul_sel_type mul_sel;
      logic        acc_load;
      logic        avg_write;
      logic        pulse_write;
      logic        commit;
   } seq_ctrl_type;

   // control store: five steps per motor, then one commit step
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type word;
      word = '{mul_sel: MUL_NONE, acc_load: 1'b0, avg_write: 1'b0, pulse_write: 1'b0,
               jump: JMP_FINISH, target: STEP_MUL_CMD};
      unique case (step)
         STEP_MUL_CMD: begin
            word.mul_sel = MUL_CMD;
            word.jump    = JMP_NEXT;
         end
         STEP_MUL_PREV: begin
            word.mul_sel  = MUL_PREV;
            word.acc_load = 1'b1;
            word.jump     = JMP_NEXT;
         end
         STEP_AVG: begin
            word.avg_write = 1'b1;
            word.jump      = JMP_NEXT;
         end
         STEP_MUL_SPAN: begin
            word.mul_sel = MUL_SPAN;
            word.jump    = JMP_NEXT;
         end
         STEP_MAP: begin
            word.pulse_write = 1'b1;
            word.jump        = JMP_LOOP;
            word.target      = STEP_MUL_CMD;
         end
         default: begin
            word.jump = JMP_FINISH;
         end
      endcase
      return word;
   endfunction

endpackage

@@ hw/rtl/escmps_sequencer.sv @@
// ----------------------------------------------------------------------------
// escmps_sequencer
// Step counter, motor loop counter and control store readout.
// ----------------------------------------------------------------------------
module escmps_sequencer
   import escmps_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
   parameter int IDX_W       = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   output logic               busy,
   output logic [IDX_W-1:0]   motor_idx,
   output seq_ctrl_type       ctrl
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MOTOR_COUNT - 1);

   logic             busy_ff, busy_in;
   step_type         step_ff, step_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   ucode_type        word;

   assign word = ucode_rom(step_ff);

   // next step and loop count
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      idx_in  = idx_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = STEP_MUL_CMD;
            idx_in  = '0;
         end
      end else begin
         unique case (word.jump)
            JMP_NEXT: begin
               step_in = step_ff + 3'd1;
            end
            JMP_LOOP: begin
               if (idx_ff == LAST_IDX) begin
                  step_in = step_ff + 3'd1;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  step_in = word.target;
               end
            end
            default: begin
               if (out_free) begin
                  busy_in = 1'b0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_MUL_CMD;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         idx_ff  <= idx_in;
      end
   end

   // control word gated by activity
   always_comb begin
      ctrl.mul_sel     = busy_ff ? word.mul_sel : MUL_NONE;
      ctrl.acc_load    = busy_ff && word.acc_load;
      ctrl.avg_write   = busy_ff && word.avg_write;
      ctrl.pulse_write = busy_ff && word.pulse_write;
      ctrl.commit      = busy_ff && (word.jump == JMP_FINISH) && out_free;
   end

   assign busy      = busy_ff;
   assign motor_idx = idx_ff;

endmodule

@@ hw/rtl/esc_arming_motor_pulse_shaper_top.sv @@
// A new input transaction is accepted only while the sequencer is idle, after the previous commit.
// Each transaction runs through the one shared 17x17 multiplier: three products per motor.
// A finished result waits in the output register; the commit step stalls while it is full and not taken.
// Reset: synchronous, clears registers to defaults, averages to zero, phase to low hold.
// ----------------------------------------------------------------------------
// esc_arming_motor_pulse_shaper_top
// Per-motor exponential smoothing, pulse mapping and ESC arming sequence.
// ----------------------------------------------------------------------------
module esc_arming_motor_pulse_shaper_top
   import escmps_pkg::*;
#(
   parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
   localparam int IN_W  = (((MOTOR_COUNT * CMD_W + NOW_W) + 7) / 8) * 8,
   localparam int OUT_W = (((MOTOR_COUNT * PULSE_W + PHASE_W) + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // motor_cmd_a, motor_cmd_b, motor_cmd_c, motor_cmd_d (18 bit each), now_ms (32 bit)
   input  logic [IN_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pulse_a, pulse_b, pulse_c, pulse_d (16 bit each), arm_phase (2 bit), zero fill
   output logic [OUT_W-1:0] rsp_tdata
);

   localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   logic             seq_busy;
   logic             out_free;
   logic [IDX_W-1:0] motor_idx;
   seq_ctrl_type     seq_ctrl;

   escmps_sequencer #(
      .MOTOR_COUNT (MOTOR_COUNT),
      .IDX_W       (IDX_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_tvalid && req_tready),
      .out_free  (out_free),
      .busy      (seq_busy),
      .motor_idx (motor_idx),
      .ctrl      (seq_ctrl)
   );

   assign req_tready = !seq_busy;

   // configuration registers
   logic [15:0] pulse_low_ff, pulse_high_ff, period_ff;
   logic [15:0] low_hold_ff, mid_hold_ff, mid_pulse_ff;
   logic [16:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_low_ff  <= RST_PULSE_LOW;
         pulse_high_ff <= RST_PULSE_HIGH;
         period_ff     <= RST_PERIOD;
         low_hold_ff   <= RST_LOW_HOLD;
         mid_hold_ff   <= RST_MID_HOLD;
         mid_pulse_ff  <= RST_MID_PULSE;
         alpha_ff      <= RST_ALPHA;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PULSE_LOW:    pulse_low_ff  <= csr_wdata[15:0];
            CSR_PULSE_HIGH:   pulse_high_ff <= csr_wdata[15:0];
            CSR_PERIOD:       period_ff     <= csr_wdata[15:0];
            CSR_LOW_HOLD:     low_hold_ff   <= csr_wdata[15:0];
            CSR_MID_HOLD:     mid_hold_ff   <= csr_wdata[15:0];
            CSR_MID_PULSE:    mid_pulse_ff  <= csr_wdata[15:0];
            CSR_SMOOTH_ALPHA: alpha_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // input transaction capture
   logic [CMD_W-1:0] cmd_ff [MOTOR_COUNT];
   logic [NOW_W-1:0] now_ff;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            cmd_ff[i] <= req_tdata[i*CMD_W +: CMD_W];
         end
         now_ff <= req_tdata[MOTOR_COUNT*CMD_W +: NOW_W];
      end
   end

   // derived register values
   logic [Q16_W-1:0]   alpha_sat, beta;
   logic signed [17:0] span;
   logic               span_neg;
   logic [17:0]        span_abs;
   logic [15:0]        span_mag;
   logic [PULSE_W-1:0] limit;

   assign alpha_sat = (alpha_ff > Q16_ONE) ? Q16_ONE : alpha_ff;
   assign beta      = Q16_ONE - alpha_sat;
   assign span      = $signed({2'b00, pulse_high_ff}) - $signed({2'b00, pulse_low_ff});
   assign span_neg  = span[17];
   assign span_abs  = span_neg ? 18'(-span) : 18'(span);
   assign span_mag  = span_abs[15:0];
   assign limit     = (period_ff == '0) ? DEFAULT_PERIOD : period_ff;

   // selected motor operands
   logic [CMD_W-1:0] cmd_sel;
   logic [Q16_W-1:0] cmd_clamped;
   logic [Q16_W-1:0] avg_ff [MOTOR_COUNT];
   logic [Q16_W-1:0] avg_sel;

   assign cmd_sel = cmd_ff[motor_idx];
   assign avg_sel = avg_ff[motor_idx];

   // negative command reads as zero, above full as full
   always_comb begin
      if (cmd_sel[CMD_W-1]) begin
         cmd_clamped = '0;
      end else if (cmd_sel[Q16_W-1:0] > Q16_ONE) begin
         cmd_clamped = Q16_ONE;
      end else begin
         cmd_clamped = cmd_sel[Q16_W-1:0];
      end
   end

   // shared multiplier
   logic [Q16_W-1:0]  op_a, op_b;
   logic [PROD_W-1:0] prod_ff;

   always_comb begin
      unique case (seq_ctrl.mul_sel)
         MUL_CMD: begin
            op_a = alpha_sat;
            op_b = cmd_clamped;
         end
         MUL_PREV: begin
            op_a = beta;
            op_b = avg_sel;
         end
         MUL_SPAN: begin
            op_a = {1'b0, span_mag};
            op_b = avg_sel;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // smoothing accumulator
   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] avg_sum;

   assign avg_sum = acc_ff + {1'b0, prod_ff};

   always_ff @(posedge clock) begin
      if (seq_ctrl.acc_load) begin
         acc_ff <= {1'b0, prod_ff} + ROUND_HALF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            avg_ff[i] <= '0;
         end
      end else if (seq_ctrl.avg_write) begin
         avg_ff[motor_idx] <= avg_sum[32:16];
      end
   end

   // pulse mapping, rounded half away from zero, clamped to the period
   logic [ACC_W-1:0]   map_rnd;
   logic [16:0]        map_q;
   logic signed [18:0] map_p;
   logic [PULSE_W-1:0] map_pulse;
   logic [PULSE_W-1:0] pulse_ff [MOTOR_COUNT];

   assign map_rnd = {1'b0, prod_ff} + ROUND_HALF;
   assign map_q   = map_rnd[32:16];
   assign map_p   = span_neg ? ($signed({3'b000, pulse_low_ff}) - $signed({2'b00, map_q}))
                             : ($signed({3'b000, pulse_low_ff}) + $signed({2'b00, map_q}));

   always_comb begin
      if (map_p < 0) begin
         map_pulse = '0;
      end else if (map_p > $signed({3'b000, limit})) begin
         map_pulse = limit;
      end else begin
         map_pulse = map_p[PULSE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctrl.pulse_write) begin
         pulse_ff[motor_idx] <= map_pulse;
      end
   end

   // arming phase state
   phase_type          phase_ff, phase_in;
   logic [NOW_W-1:0]   start_ff, start_in, start_eff, elapsed;
   logic               start_taken_ff;
   logic [PULSE_W-1:0] hold_low, hold_mid;
   logic [PULSE_W-1:0] out_pulse [MOTOR_COUNT];

   assign start_eff = start_taken_ff ? start_ff : now_ff;
   assign elapsed   = now_ff - start_eff;
   assign hold_low  = (pulse_low_ff > limit) ? limit : pulse_low_ff;
   assign hold_mid  = (mid_pulse_ff > limit) ? limit : mid_pulse_ff;

   // hold widths follow the phase at the start of the transaction
   always_comb begin
      phase_in = phase_ff;
      start_in = start_eff;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         out_pulse[i] = pulse_ff[i];
      end
      unique case (phase_ff)
         PH_LOW: begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
               out_pulse[i] = hold_low;
            end
            if (elapsed >= {16'd0, low_hold_ff}) begin
               phase_in = PH_MID;
               start_in = now_ff;
            end
         end
         PH_MID: begin
            for (int i = 0; i < MOTOR_COUNT; i++) begin
               out_pulse[i] = hold_mid;
            end
            if (elapsed >= {16'd0, mid_hold_ff}) begin
               phase_in = PH_ARMED;
               start_in = now_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LOW;
         start_ff       <= '0;
         start_taken_ff <= 1'b0;
      end else if (seq_ctrl.commit) begin
         phase_ff       <= phase_in;
         start_ff       <= start_in;
         start_taken_ff <= 1'b1;
      end
   end

   // output register
   logic               rsp_valid_ff;
   logic [PULSE_W-1:0] rsp_pulse_ff [MOTOR_COUNT];
   logic [PHASE_W-1:0] rsp_phase_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq_ctrl.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_ctrl.commit) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            rsp_pulse_ff[i] <= out_pulse[i];
         end
         rsp_phase_ff <= phase_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
         rsp_tdata[i*PULSE_W +: PULSE_W] = rsp_pulse_ff[i];
      end
      rsp_tdata[MOTOR_COUNT*PULSE_W +: PHASE_W] = rsp_phase_ff;
   end

`ifndef SYNTH
   // the sequencer only goes idle through a commit
   a_idle_after_commit: assert property (@(posedge clock) disable iff (reset)
      $fell(seq_busy) |-> $past(seq_ctrl.commit))
      else $error("sequencer left busy without commit");

   // commit only after the last motor has been mapped
   a_commit_last_motor: assert property (@(posedge clock) disable iff (reset)
      seq_ctrl.commit |-> (motor_idx == IDX_W'(MOTOR_COUNT - 1)))
      else $error("commit before last motor");

   // phase moves only on a commit
   a_phase_on_commit: assert property (@(posedge clock) disable iff (reset)
      !$stable(phase_ff) |-> $past(seq_ctrl.commit))
      else $error("phase changed without commit");
`endif

endmodule
